### rtl/assert_macros.svh
// Assertion macros used by the checker file of the arbiter.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define DPQA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DPQA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dpqa_pkg.sv
// Shared codes and types of the dual priority queue arbiter.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package dpqa_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_READER = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_SMALL     = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_NULL      = 3'd5;

	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_READ    = 1'b1;

	localparam logic [2:0] KIND_PROC    = 3'd0;
	localparam logic [2:0] KIND_BLOCKED = 3'd6;

	localparam logic REG_READER = 1'b0;
	localparam logic REG_URGENT = 1'b1;

	localparam logic [6:0] URGENT_RESET = 7'd90;

	// Control carried from the decision cycle to the result cycle.
	typedef struct packed {
		logic       valid;
		logic       pop;
		logic       sel_low;
		logic [2:0] status;
	} ctl_t;

endpackage

`default_nettype wire

### rtl/dual_priority_queue_arbiter.sv
// Dual priority queue arbiter: two memory-backed FIFOs of event handles.
// Results: stage 1 registers the decision, stage 2 the result and its strobe.
// Throughput: one item per cycle; busy stays low, since every item touches
// one entry of one queue memory and its pointers are updated at acceptance.
// Reset: arst_n clears pointers, counts, drop count, configuration, stage
// control and done at once; the queue memories need no clearing pass.
`default_nettype none

module dual_priority_queue_arbiter #(
	parameter int QUEUE_DEPTH  = 8192,
	parameter int RECORD_BYTES = 64,
	parameter int HANDLE_BITS  = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               func,
	input  wire logic [HANDLE_BITS-1:0]             event_handle,
	input  wire logic [2:0]                         event_kind,
	input  wire logic [15:0]                        read_space,
	output logic                                    done,
	output logic [2:0]                              status,
	output logic [31:0]                             out_handle,
	output logic [2:0]                              out_kind,
	output logic                                    served_queue,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]        pending_high,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]        pending_low,
	output logic [31:0]                             dropped_total,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);
	import dpqa_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = CW + 7;
	localparam int EW = HANDLE_BITS + 3;

	// Configuration
	logic       reader_q;
	logic [6:0] urgent_q;
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reader_q <= 1'b0;
			urgent_q <= URGENT_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == REG_READER) reader_q <= pwdata[0];
			else                        urgent_q <= pwdata[6:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_READER) prdata = {31'd0, reader_q};
		else                        prdata = {25'd0, urgent_q};
	end

	// Queue state
	logic [AW-1:0] hi_head_q, lo_head_q;
	logic [CW-1:0] hi_cnt_q, lo_cnt_q;
	logic [31:0]   drop_q;

	logic          accept;
	logic          is_read;
	logic          to_high;
	logic [CW:0]   hi_sum, lo_sum;
	logic [AW-1:0] hi_tail, lo_tail;
	logic [PW-1:0] hi_scaled, lo_scaled, thr;
	logic          hi_full, lo_full, sel_low;
	logic          hi_we, lo_we, hi_re, lo_re;
	logic [2:0]    status_d;
	logic          drop_inc;
	logic [EW-1:0] wdata;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign is_read = (func == FUNC_READ);
	assign to_high = (event_kind == KIND_PROC) || (event_kind == KIND_BLOCKED);
	assign wdata   = {event_kind, event_handle};

	assign hi_sum  = (CW+1)'(hi_head_q) + (CW+1)'(hi_cnt_q);
	assign lo_sum  = (CW+1)'(lo_head_q) + (CW+1)'(lo_cnt_q);
	assign hi_tail = (hi_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		AW'(hi_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(hi_sum);
	assign lo_tail = (lo_sum >= (CW+1)'(QUEUE_DEPTH)) ?
		AW'(lo_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(lo_sum);
	assign hi_full = (hi_cnt_q == CW'(QUEUE_DEPTH));
	assign lo_full = (lo_cnt_q == CW'(QUEUE_DEPTH));

	// floor(cnt*100/D) >= u is the same test as cnt*100 >= u*D
	assign hi_scaled = PW'(hi_cnt_q) * PW'(100);
	assign lo_scaled = PW'(lo_cnt_q) * PW'(100);
	assign thr       = PW'(urgent_q) * PW'(QUEUE_DEPTH);
	assign sel_low   = !((hi_scaled >= thr) || ((hi_cnt_q != '0) && (lo_scaled < thr)));

	always_comb begin
		hi_we    = 1'b0;
		lo_we    = 1'b0;
		hi_re    = 1'b0;
		lo_re    = 1'b0;
		drop_inc = 1'b0;
		status_d = ST_OK;
		if (!is_read) begin
			priority if (!reader_q) begin
				status_d = ST_NO_READER;
			end else if (to_high ? hi_full : lo_full) begin
				status_d = ST_FULL;
				drop_inc = 1'b1;
			end else begin
				hi_we = to_high;
				lo_we = !to_high;
			end
		end else begin
			priority if (read_space < 16'(RECORD_BYTES)) begin
				status_d = ST_SMALL;
			end else if ((hi_cnt_q == '0) && (lo_cnt_q == '0)) begin
				status_d = ST_EMPTY;
			end else if (sel_low) begin
				if (lo_cnt_q == '0) status_d = ST_EMPTY;
				else                lo_re    = 1'b1;
			end else begin
				if (hi_cnt_q == '0) status_d = ST_EMPTY;
				else                hi_re    = 1'b1;
			end
		end
	end

	logic [CW-1:0] hi_cnt_d, lo_cnt_d;
	logic [31:0]   drop_d;

	always_comb begin
		hi_cnt_d = hi_cnt_q;
		lo_cnt_d = lo_cnt_q;
		if (accept && hi_we) hi_cnt_d = hi_cnt_q + CW'(1);
		if (accept && hi_re) hi_cnt_d = hi_cnt_q - CW'(1);
		if (accept && lo_we) lo_cnt_d = lo_cnt_q + CW'(1);
		if (accept && lo_re) lo_cnt_d = lo_cnt_q - CW'(1);
		drop_d = (accept && drop_inc) ? drop_q + 32'd1 : drop_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_head_q <= '0;
			lo_head_q <= '0;
			hi_cnt_q  <= '0;
			lo_cnt_q  <= '0;
			drop_q    <= '0;
		end else begin
			hi_cnt_q <= hi_cnt_d;
			lo_cnt_q <= lo_cnt_d;
			drop_q   <= drop_d;
			if (accept && hi_re)
				hi_head_q <= (hi_head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : hi_head_q + AW'(1);
			if (accept && lo_re)
				lo_head_q <= (lo_head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : lo_head_q + AW'(1);
		end
	end

	// Queue memories: one write or one read per cycle, registered read data.
	// A pop never meets a push to the same entry in one cycle, and a write
	// lands before any later read of that entry is issued.
	logic [EW-1:0] hi_mem [QUEUE_DEPTH];
	logic [EW-1:0] lo_mem [QUEUE_DEPTH];
	logic [EW-1:0] hi_rd_s1, lo_rd_s1;

	always_ff @(posedge clk) begin
		if (accept && hi_we) hi_mem[hi_tail] <= wdata;
		if (accept && hi_re) hi_rd_s1 <= hi_mem[hi_head_q];
	end

	always_ff @(posedge clk) begin
		if (accept && lo_we) lo_mem[lo_tail] <= wdata;
		if (accept && lo_re) lo_rd_s1 <= lo_mem[lo_head_q];
	end

	// Stage 1: hold the decision and the counts after this step
	ctl_t          ctl_s1;
	logic [CW-1:0] hi_cnt_s1, lo_cnt_s1;
	logic [31:0]   drop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid   <= accept;
			ctl_s1.pop     <= hi_re || lo_re;
			ctl_s1.sel_low <= is_read && (status_d != ST_SMALL) &&
				!((hi_cnt_q == '0) && (lo_cnt_q == '0)) && sel_low;
			ctl_s1.status  <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		hi_cnt_s1 <= hi_cnt_d;
		lo_cnt_s1 <= lo_cnt_d;
		drop_s1   <= drop_d;
	end

	// Stage 2: check the popped entry and register the result
	logic [EW-1:0]          ent;
	logic [HANDLE_BITS-1:0] ent_handle;
	logic [63:0]            handle_ext;
	logic [2:0]             status_r;
	logic [31:0]            handle_r;
	logic [2:0]             kind_r;

	assign ent        = ctl_s1.sel_low ? lo_rd_s1 : hi_rd_s1;
	assign ent_handle = ent[HANDLE_BITS-1:0];
	assign handle_ext = 64'(ent_handle);

	always_comb begin
		status_r = ctl_s1.status;
		handle_r = '0;
		kind_r   = '0;
		if (ctl_s1.pop) begin
			if (ent_handle == '0) begin
				status_r = ST_NULL;
			end else begin
				handle_r = handle_ext[31:0];
				kind_r   = ent[EW-1:HANDLE_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= ctl_s1.valid;
	end

	always_ff @(posedge clk) begin
		status        <= status_r;
		out_handle    <= handle_r;
		out_kind      <= kind_r;
		served_queue  <= ctl_s1.sel_low;
		pending_high  <= hi_cnt_s1;
		pending_low   <= lo_cnt_s1;
		dropped_total <= drop_s1;
	end

endmodule

`default_nettype wire

### rtl/dpqa_checker.sv
// Port-level checker for the dual priority queue arbiter, bound to the top.
// Depends on dpqa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dpqa_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        func,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [31:0] out_handle,
	input wire logic [2:0]  out_kind
);
	import dpqa_pkg::*;

	// each accepted transfer gives its result, and no result comes without one
	`DPQA_ASSERT(a_latency, clk, arst_n, start && !busy |-> ##2 done, "result missing")
	`DPQA_ASSERT(a_no_spurious, clk, arst_n, done |-> $past(start && !busy, 2), "spurious result")
	// a failed transfer or a null read delivers no payload
	`DPQA_ASSERT(a_zero_payload, clk, arst_n,
		done && (status != ST_OK) |-> (out_handle == '0) && (out_kind == '0),
		"payload on error")
	// an ok read always delivers a non-null handle
	`DPQA_ASSERT(a_ok_read_nonnull, clk, arst_n,
		done && (status == ST_OK) && $past(func, 2) |-> (out_handle != '0),
		"null handle reported ok")
	`DPQA_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !done, "result during reset")

endmodule

bind dual_priority_queue_arbiter dpqa_port_checker u_dpqa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.func(func),
	.done(done),
	.status(status),
	.out_handle(out_handle),
	.out_kind(out_kind)
);

`default_nettype wire
